/* rtl/core/sctp_pkg.sv */
package sctp_pkg;

    localparam int NUM_SETS   = 128;
    localparam int NUM_WAYS   = 8;
    localparam int LINE_BYTES = 32;

    localparam int ADDR_W   = 32;
    localparam int OFFSET_W = $clog2(LINE_BYTES);
    localparam int INDEX_W  = $clog2(NUM_SETS);
    localparam int TAG_W    = ADDR_W - OFFSET_W - INDEX_W;
    localparam int WAY_W    = $clog2(NUM_WAYS);
    localparam int PLRU_W   = NUM_WAYS - 1;
    localparam int ID_W     = 3;
    localparam int ACT_W    = 3;
    localparam int BUS_W    = 2;

    // action codes
    localparam logic [ACT_W-1:0] ACT_CPU_READ  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_CPU_WRITE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_BUS_READ  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_BUS_WRITE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_BUS_RDX   = 3'd4;

    // bus request codes
    localparam logic [BUS_W-1:0] BUS_NONE  = 2'd0;
    localparam logic [BUS_W-1:0] BUS_READ  = 2'd1;
    localparam logic [BUS_W-1:0] BUS_WRITE = 2'd2;
    localparam logic [BUS_W-1:0] BUS_RDX   = 2'd3;

    // tree plru: bit 6 root, bit 5 left pair node, bit 4 right pair node, bits 3..0 leaves
    localparam logic [PLRU_W-1:0] TOUCH_SET_W0 = 7'b1101000;
    localparam logic [PLRU_W-1:0] TOUCH_KEEP_W1 = 7'b0010111;
    localparam logic [PLRU_W-1:0] TOUCH_SET_W1 = 7'b1100000;
    localparam logic [PLRU_W-1:0] TOUCH_KEEP_W23 = 7'b0011011;
    localparam logic [PLRU_W-1:0] TOUCH_SET_W2 = 7'b1000100;
    localparam logic [PLRU_W-1:0] TOUCH_KEEP_W45 = 7'b0101101;
    localparam logic [PLRU_W-1:0] TOUCH_SET_W4 = 7'b0010010;
    localparam logic [PLRU_W-1:0] TOUCH_KEEP_W67 = 7'b0101110;
    localparam logic [PLRU_W-1:0] TOUCH_SET_W3 = 7'b1000000;
    localparam logic [PLRU_W-1:0] TOUCH_SET_W5 = 7'b0010000;
    localparam logic [PLRU_W-1:0] TOUCH_SET_W6 = 7'b0000001;

    typedef struct packed {
        logic [NUM_WAYS-1:0][TAG_W-1:0] tags;
        logic [NUM_WAYS-1:0]            valid;
        logic [PLRU_W-1:0]              plru;
    } set_row_t;

    typedef struct packed {
        logic              hit;
        logic [WAY_W-1:0]  way;
        logic [BUS_W-1:0]  bus_request;
        logic              evicted;
        logic              invalidated;
    } result_t;

    function automatic logic [PLRU_W-1:0] plru_touch(input logic [PLRU_W-1:0] w,
                                                     input logic [WAY_W-1:0] way);
        logic [PLRU_W-1:0] r;
        case (way)
            3'd0:    r = w | TOUCH_SET_W0;
            3'd1:    r = (w & TOUCH_KEEP_W1) | TOUCH_SET_W1;
            3'd2:    r = (w & TOUCH_KEEP_W23) | TOUCH_SET_W2;
            3'd3:    r = (w & TOUCH_KEEP_W23) | TOUCH_SET_W3;
            3'd4:    r = (w & TOUCH_KEEP_W45) | TOUCH_SET_W4;
            3'd5:    r = (w & TOUCH_KEEP_W45) | TOUCH_SET_W5;
            3'd6:    r = (w & TOUCH_KEEP_W67) | TOUCH_SET_W6;
            default: r = w & TOUCH_KEEP_W67;
        endcase
        return r;
    endfunction

    function automatic logic [WAY_W-1:0] plru_victim(input logic [PLRU_W-1:0] w);
        logic [WAY_W-1:0] v;
        if (!w[6])
        begin
            if (!w[5])
                v = w[3] ? 3'd1 : 3'd0;
            else
                v = w[2] ? 3'd3 : 3'd2;
        end
        else
        begin
            if (!w[4])
                v = w[1] ? 3'd5 : 3'd4;
            else
                v = w[0] ? 3'd7 : 3'd6;
        end
        return v;
    endfunction

endpackage

/* rtl/core/snooping_cache_tag_plru_controller_unit.sv */
// tag, valid and tree plru controller of an 8-way set-associative cache with
// snoop invalidation.
// command channel: an item (action, address, requester_id) is taken at a clock
// edge where start is high and busy is low. one item may be taken every cycle.
// result channel: result_valid is high for exactly one cycle with hit, way,
// bus_request, evicted and invalidated; the receiver cannot stall it, so every
// result is taken as it appears. an item passes the staging registers and then the result
// register before its result is shown; throughput is one item per cycle.
// per-set state (tags, valid bits, plru word) sits in one synchronous ram row,
// read at the accepting edge and written back in the following cycle; a same-set item
// directly behind gets the written row forwarded instead of the stale read.
// config channel: cfg_data is the cache id, written when cfg_valid and
// cfg_ready are both high; cfg_ready is always high.
// reset: own id clears to 0, then a clearing pass writes every set row (NUM_SETS = 128)
// to zero, one row a cycle; busy is high during that pass.
module snooping_cache_tag_plru_controller_unit
    import sctp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [ACT_W-1:0]  action,
    input  logic [ADDR_W-1:0] address,
    input  logic [ID_W-1:0]   requester_id,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ID_W-1:0]   cfg_data,
    output logic              result_valid,
    output logic              hit,
    output logic [WAY_W-1:0]  way,
    output logic [BUS_W-1:0]  bus_request,
    output logic              evicted,
    output logic              invalidated
);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [INDEX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [ID_W-1:0]     own_id_reg;

    set_row_t            mem [NUM_SETS];
    set_row_t            row_reg;

    logic                stg_vld_reg;
    logic [ACT_W-1:0]    stg_action_reg;
    logic [TAG_W-1:0]    stg_tag_reg;
    logic [INDEX_W-1:0]  stg_set_reg;
    logic [ID_W-1:0]     stg_req_reg;

    logic                res_vld_reg;
    result_t             res_reg;

    logic                accept;
    logic [INDEX_W-1:0]  in_set;
    set_row_t            new_row;
    logic                row_we;
    result_t             result;
    logic                wr_en;
    logic [INDEX_W-1:0]  wr_addr;
    set_row_t            wr_data;

    assign busy      = (state_reg != ST_RUN);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign in_set    = address[OFFSET_W +: INDEX_W];

    sctp_lookup u_lookup (
        .action       (stg_action_reg),
        .tag          (stg_tag_reg),
        .requester_id (stg_req_reg),
        .own_id       (own_id_reg),
        .row          (row_reg),
        .new_row      (new_row),
        .row_we       (row_we),
        .result       (result)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == INDEX_W'(NUM_SETS - 1))
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next   = ST_CLEAR;
                clr_cnt_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = stg_vld_reg && row_we;
            wr_addr = stg_set_reg;
            wr_data = new_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            own_id_reg  <= '0;
            stg_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (cfg_valid && cfg_ready)
                own_id_reg <= cfg_data;
            stg_vld_reg <= accept;
            res_vld_reg <= stg_vld_reg;
        end
    end

    // set ram: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (accept)
        begin
            // forward the row being written back when the next item hits the same set
            if (stg_vld_reg && row_we && (stg_set_reg == in_set))
                row_reg <= new_row;
            else
                row_reg <= mem[in_set];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_action_reg <= action;
            stg_tag_reg    <= address[ADDR_W-1 -: TAG_W];
            stg_set_reg    <= in_set;
            stg_req_reg    <= requester_id;
        end
        if (stg_vld_reg)
            res_reg <= result;
    end

    assign result_valid = res_vld_reg;
    assign hit          = res_reg.hit;
    assign way          = res_reg.way;
    assign bus_request  = res_reg.bus_request;
    assign evicted      = res_reg.evicted;
    assign invalidated  = res_reg.invalidated;

endmodule

/* rtl/core/sctp_lookup.sv */
module sctp_lookup
    import sctp_pkg::*;
(
    input  logic [ACT_W-1:0] action,
    input  logic [TAG_W-1:0] tag,
    input  logic [ID_W-1:0]  requester_id,
    input  logic [ID_W-1:0]  own_id,
    input  set_row_t         row,
    output set_row_t         new_row,
    output logic             row_we,
    output result_t          result
);

    logic [NUM_WAYS-1:0] match;
    logic                any_match;
    logic [WAY_W-1:0]    hit_way;
    logic                any_invalid;
    logic [WAY_W-1:0]    free_way;
    logic [WAY_W-1:0]    use_way;
    logic                is_cpu;
    logic                is_snoop;

    always_comb
    begin
        match    = '0;
        hit_way  = '0;
        free_way = '0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            match[i] = row.valid[i] && (row.tags[i] == tag);
        end
        // highest matching way wins
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            if (match[i])
                hit_way = WAY_W'(i);
        end
        // lowest invalid way
        for (int i = NUM_WAYS - 1; i >= 0; i--)
        begin
            if (!row.valid[i])
                free_way = WAY_W'(i);
        end
    end

    assign any_match   = |match;
    assign any_invalid = ~&row.valid;
    assign is_cpu      = action inside {ACT_CPU_READ, ACT_CPU_WRITE};
    assign is_snoop    = (action inside {ACT_BUS_READ, ACT_BUS_WRITE, ACT_BUS_RDX}) &&
                         (requester_id != own_id);
    assign use_way     = any_match ? hit_way : (any_invalid ? free_way : plru_victim(row.plru));

    always_comb
    begin
        new_row = row;
        row_we  = 1'b0;
        result  = '0;
        if (is_cpu)
        begin
            row_we         = 1'b1;
            result.hit     = any_match;
            result.way     = use_way;
            new_row.plru   = plru_touch(row.plru, use_way);
            if (any_match)
            begin
                result.bus_request = (action == ACT_CPU_WRITE) ? BUS_WRITE : BUS_NONE;
            end
            else
            begin
                result.bus_request     = (action == ACT_CPU_WRITE) ? BUS_RDX : BUS_READ;
                result.evicted         = !any_invalid;
                new_row.tags[use_way]  = tag;
                new_row.valid[use_way] = 1'b1;
            end
        end
        else if (is_snoop)
        begin
            result.hit = any_match;
            result.way = hit_way;
            if (action != ACT_BUS_READ)
            begin
                row_we             = 1'b1;
                new_row.valid      = row.valid & ~match;
                result.invalidated = any_match;
            end
        end
    end

endmodule

/* sim/snooping_cache_tag_plru_controller_unit_test.sv */
`timescale 1ns / 1ps

module snooping_cache_tag_plru_controller_unit_test;

    import sctp_pkg::*;

    // actions the block ignores
    localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

    typedef struct {
        logic [ACT_W-1:0]  act;
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   req;
        bit                typed;
        result_t           res;
    } cmd_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [ACT_W-1:0]  action = '0;
    logic [ADDR_W-1:0] address = '0;
    logic [ID_W-1:0]   requester_id = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ID_W-1:0]   cfg_data = '0;
    logic              result_valid;
    logic              hit;
    logic [WAY_W-1:0]  way;
    logic [BUS_W-1:0]  bus_request;
    logic              evicted;
    logic              invalidated;

    // shadow copy of the tag, valid and plru state
    bit [TAG_W-1:0]  tag_copy [NUM_SETS][NUM_WAYS];
    bit              valid_copy [NUM_SETS][NUM_WAYS];
    bit [PLRU_W-1:0] plru_copy [NUM_SETS];
    logic [ID_W-1:0] own_id_copy = '0;

    result_t  pending_lookups [$];
    cmd_row_t directed_cmds [$];
    int       sender_idle_pct = 0;
    int       mismatch_count = 0;

    snooping_cache_tag_plru_controller_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .address      (address),
        .requester_id (requester_id),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .hit          (hit),
        .way          (way),
        .bus_request  (bus_request),
        .evicted      (evicted),
        .invalidated  (invalidated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t cache_lookup(input logic [ACT_W-1:0] act,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic [ID_W-1:0] req);
        logic [INDEX_W-1:0] set_idx;
        logic [TAG_W-1:0]   tag;
        logic [PLRU_W-1:0]  pl;
        logic               hi;
        logic               mid;
        bit                 found;
        int                 w;
        result_t            r;
        set_idx = addr[OFFSET_W +: INDEX_W];
        tag = addr[ADDR_W-1 -: TAG_W];
        pl = plru_copy[set_idx];
        found = 1'b0;
        r = '0;
        if (act == ACT_CPU_READ || act == ACT_CPU_WRITE)
        begin
            for (w = 0; w < NUM_WAYS; w++)
                if (valid_copy[set_idx][w] && tag_copy[set_idx][w] == tag)
                begin
                    r.hit = 1'b1;
                    r.way = WAY_W'(w);
                end
            if (r.hit)
                r.bus_request = (act == ACT_CPU_WRITE) ? BUS_WRITE : BUS_NONE;
            else
            begin
                for (w = 0; w < NUM_WAYS; w++)
                    if (!found && !valid_copy[set_idx][w])
                    begin
                        r.way = WAY_W'(w);
                        found = 1'b1;
                    end
                if (!found)
                begin
                    // walk the tree: root bit 6, pair nodes 5/4, leaves 3..0
                    hi = pl[6];
                    mid = pl[5 - hi];
                    r.way = {hi, mid, pl[3 - {hi, mid}]};
                    r.evicted = 1'b1;
                end
                tag_copy[set_idx][r.way] = tag;
                valid_copy[set_idx][r.way] = 1'b1;
                r.bus_request = (act == ACT_CPU_WRITE) ? BUS_RDX : BUS_READ;
            end
            // point every node on the used way's path away from it
            pl[6] = ~r.way[2];
            pl[5 - r.way[2]] = ~r.way[1];
            pl[3 - r.way[2:1]] = ~r.way[0];
            plru_copy[set_idx] = pl;
        end
        else if (act <= ACT_BUS_RDX && req != own_id_copy)
        begin
            for (w = 0; w < NUM_WAYS; w++)
                if (valid_copy[set_idx][w] && tag_copy[set_idx][w] == tag)
                begin
                    r.hit = 1'b1;
                    r.way = WAY_W'(w);
                    if (act != ACT_BUS_READ)
                    begin
                        valid_copy[set_idx][w] = 1'b0;
                        r.invalidated = 1'b1;
                    end
                end
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] line_addr(input int tag,
                                                    input int set_idx,
                                                    input int off);
        return {TAG_W'(tag), INDEX_W'(set_idx), OFFSET_W'(off)};
    endfunction

    function automatic cmd_row_t cmd_row(input logic [ACT_W-1:0] act,
                                         input logic [ADDR_W-1:0] addr,
                                         input int req,
                                         input bit typed,
                                         input logic h,
                                         input int w,
                                         input logic [BUS_W-1:0] bus,
                                         input logic ev,
                                         input logic inv);
        cmd_row_t c;
        c.act = act;
        c.addr = addr;
        c.req = ID_W'(req);
        c.typed = typed;
        c.res.hit = h;
        c.res.way = WAY_W'(w);
        c.res.bus_request = bus;
        c.res.evicted = ev;
        c.res.invalidated = inv;
        return c;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    // one command beat; the lookup is predicted at the accepting edge
    task automatic issue(input cmd_row_t c);
        result_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        action <= c.act;
        address <= c.addr;
        requester_id <= c.req;
        do
            @(posedge clk);
        while (busy);
        predicted = cache_lookup(c.act, c.addr, c.req);
        pending_lookups.push_back(c.typed ? c.res : predicted);
    endtask

    task automatic set_own_id(input logic [ID_W-1:0] id);
        start <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= id;
        do
            @(posedge clk);
        while (!cfg_ready);
        own_id_copy = id;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int target);
        int                 counted;
        int                 pick;
        logic [TAG_W-1:0]   tag_base;
        logic [INDEX_W-1:0] set_base;
        cmd_row_t           c;
        counted = 0;
        tag_base = TAG_W'($urandom);
        set_base = INDEX_W'($urandom);
        c = cmd_row(ACT_CPU_READ, '0, 0, 1'b0, 1'b0, 0, BUS_NONE, 1'b0, 1'b0);
        while (counted < target)
        begin
            pick = $urandom_range(0, 99);
            c.req = ID_W'($urandom_range(0, 7));
            if (pick < 40)
                c.act = ACT_CPU_READ;
            else if (pick < 64)
                c.act = ACT_CPU_WRITE;
            else if (pick < 74)
                c.act = ACT_BUS_READ;
            else if (pick < 84)
                c.act = ACT_BUS_WRITE;
            else if (pick < 92)
                c.act = ACT_BUS_RDX;
            else if (pick < 97)
            begin
                // own snoop, must be ignored
                c.act = ACT_W'($urandom_range(ACT_BUS_READ, ACT_BUS_RDX));
                c.req = own_id_copy;
            end
            else
                c.act = ACT_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
            // mostly a few sets and a dozen tags, so sets fill, hit and evict
            if ($urandom_range(0, 99) < 80)
                c.addr = {tag_base + TAG_W'($urandom_range(0, 11)),
                          set_base + INDEX_W'($urandom_range(0, 3)),
                          OFFSET_W'($urandom)};
            else
                c.addr = $urandom;
            counted++;
            issue(c);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_lookups.size() == 0)
                flag_mismatch($sformatf("unexpected result: hit %0d way %0d bus %0d ev %0d inv %0d",
                                        hit, way, bus_request, evicted, invalidated));
            else
            begin
                want = pending_lookups.pop_front();
                if (hit !== want.hit || way !== want.way || bus_request !== want.bus_request
                    || evicted !== want.evicted || invalidated !== want.invalidated)
                    flag_mismatch($sformatf({"lookup mismatch: expected hit %0d way %0d bus %0d",
                                             " ev %0d inv %0d, got hit %0d way %0d bus %0d",
                                             " ev %0d inv %0d"},
                                            want.hit, want.way, want.bus_request, want.evicted,
                                            want.invalidated, hit, way, bus_request, evicted,
                                            invalidated));
            end
        end
    end

    initial
    begin
        // fresh state, cache id 0
        directed_cmds.push_back(cmd_row(ACT_CPU_READ, line_addr(1, 5, 0), 0, 1'b1,
                                        1'b0, 0, BUS_READ, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_CPU_WRITE, line_addr(1, 5, 31), 0, 1'b1,
                                        1'b1, 0, BUS_WRITE, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_CPU_READ, line_addr(1, 5, 0), 0, 1'b1,
                                        1'b1, 0, BUS_NONE, 1'b0, 1'b0));
        // fill the rest of the set, then two plru evictions
        for (int t = 2; t <= 8; t++)
            directed_cmds.push_back(cmd_row(ACT_CPU_WRITE, line_addr(t, 5, t), 0, 1'b0,
                                            1'b0, 0, BUS_NONE, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_CPU_READ, line_addr(9, 5, 3), 0, 1'b0,
                                        1'b0, 0, BUS_NONE, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_CPU_READ, line_addr(10, 5, 7), 0, 1'b0,
                                        1'b0, 0, BUS_NONE, 1'b0, 1'b0));
        // snoops from others and from ourselves
        directed_cmds.push_back(cmd_row(ACT_BUS_READ, line_addr(2, 5, 0), 3, 1'b0,
                                        1'b0, 0, BUS_NONE, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_BUS_WRITE, line_addr(2, 5, 0), 0, 1'b1,
                                        1'b0, 0, BUS_NONE, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_BUS_WRITE, line_addr(2, 5, 0), 7, 1'b0,
                                        1'b0, 0, BUS_NONE, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_BUS_RDX, line_addr(3, 5, 9), 1, 1'b0,
                                        1'b0, 0, BUS_NONE, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_BUS_RDX, line_addr(3, 5, 9), 1, 1'b1,
                                        1'b0, 0, BUS_NONE, 1'b0, 1'b0));
        // refill goes to the lowest invalidated way
        directed_cmds.push_back(cmd_row(ACT_CPU_READ, line_addr(11, 5, 0), 0, 1'b0,
                                        1'b0, 0, BUS_NONE, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_UNUSED_LO, line_addr(1, 5, 0), 2, 1'b1,
                                        1'b0, 0, BUS_NONE, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_UNUSED_HI, line_addr(9, 5, 0), 5, 1'b1,
                                        1'b0, 0, BUS_NONE, 1'b0, 1'b0));
        // address extremes
        directed_cmds.push_back(cmd_row(ACT_CPU_READ, 32'hFFFF_FFFF, 7, 1'b1,
                                        1'b0, 0, BUS_READ, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_CPU_WRITE, 32'hFFFF_FFE0, 0, 1'b1,
                                        1'b1, 0, BUS_WRITE, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_BUS_WRITE, 32'h0000_0000, 7, 1'b1,
                                        1'b0, 0, BUS_NONE, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_CPU_WRITE, 32'h0000_0000, 0, 1'b1,
                                        1'b0, 0, BUS_RDX, 1'b0, 1'b0));
        directed_cmds.push_back(cmd_row(ACT_BUS_RDX, 32'h0000_001F, 7, 1'b1,
                                        1'b1, 0, BUS_NONE, 1'b0, 1'b1));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_cmds[i])
            issue(directed_cmds[i]);

        sender_idle_pct = 35;
        set_own_id(3'd7);
        random_traffic(500);

        sender_idle_pct = 78;
        set_own_id(3'd0);
        random_traffic(500);

        sender_idle_pct = 0;
        set_own_id(ID_W'($urandom_range(1, 6)));
        random_traffic(500);

        start <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
